[rtl/hbd_pkg.sv]
// Shared constants for the HTTP body dechunker: character codes, decode modes, CSR indexes.
package hbd_pkg;

   localparam int unsigned CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECODE_MODE    = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONTENT_LENGTH = 4'd1;

   localparam logic [1:0] MODE_RAW     = 2'd0;
   localparam logic [1:0] MODE_LENGTH  = 2'd1;
   localparam logic [1:0] MODE_CHUNKED = 2'd2;

   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_PLUS    = 8'd43;
   localparam logic [7:0] CH_MINUS   = 8'd45;
   localparam logic [7:0] CH_0       = 8'd48;
   localparam logic [7:0] CH_9       = 8'd57;
   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_F = 8'd70;
   localparam logic [7:0] CH_UPPER_X = 8'd88;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_F = 8'd102;
   localparam logic [7:0] CH_LOWER_X = 8'd120;

   localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

endpackage

[rtl/http_body_dechunker_top.sv]
// HTTP body dechunker top level: raw, content-length and chunked body decoding.
//
// Usage:
//   The request channel (req_valid/req_ready) carries one response body byte per
//   request, with req_in_last marking the final byte of the response. The
//   response channel (rsp_valid/rsp_ready) returns exactly one result per
//   request: rsp_out_valid says whether the byte belongs to the decoded body,
//   rsp_out_byte carries it (zero when dropped) and rsp_out_end echoes in_last.
//   The csr_ port writes decode_mode (index 0) and content_length (index 1);
//   write only while no request is in flight.
// Timing:
//   One request per cycle while the receiver keeps up; each result is registered
//   and appears in the cycle after its request is accepted. All parsing is done
//   by the single-byte decode logic between the request and the result register.
// Reset and stall:
//   Reset (synchronous, active high) clears the parser, the byte counter, the
//   CSRs and the result valid flag; the result payload is not reset. When the
//   receiver stalls, the result is held and req_ready drops until the result is
//   taken; a request is still taken in the same cycle the waiting result leaves.
module http_body_dechunker_top #(
   parameter int unsigned LENGTH_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_in_byte,
   input  logic                              req_in_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_out_valid,
   output logic                              rsp_out_end,
   input  logic                              csr_wr_en,
   input  logic [hbd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                       csr_wdata
);
   import hbd_pkg::*;

   typedef enum logic [3:0] {
      PH_LEAD   = 4'd0,
      PH_SIGN   = 4'd1,
      PH_ZERO   = 4'd2,
      PH_PREFIX = 4'd3,
      PH_DIGITS = 4'd4,
      PH_REST   = 4'd5,
      PH_DATA   = 4'd6,
      PH_AFTER  = 4'd7,
      PH_AFTCR  = 4'd8,
      PH_STOP   = 4'd9
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [LENGTH_BITS-1:0] accum;
      logic                   negative;
   } line_state_type;

   typedef struct packed {
      line_state_type ls;
      logic           cr;
      logic           done;
   } line_byte_type;

   // ---------------------------------------------------------------------
   // Character classes for the size line
   // ---------------------------------------------------------------------
   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return ((c >= CH_0) && (c <= CH_9)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
   endfunction

   function automatic logic [3:0] hex_digit(logic [7:0] c);
      logic [7:0] v;
      if ((c >= CH_0) && (c <= CH_9)) begin
         v = c - CH_0;
      end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
         v = c - CH_LOWER_A + HEX_ALPHA_BASE;
      end else begin
         v = c - CH_UPPER_A + HEX_ALPHA_BASE;
      end
      return v[3:0];
   endfunction

   // Shift one hex digit in, saturating at all ones.
   function automatic logic [LENGTH_BITS-1:0] accumulate(logic [LENGTH_BITS-1:0] acc,
                                                         logic [3:0] d);
      if (|acc[LENGTH_BITS-1:LENGTH_BITS-4]) begin
         return '1;
      end
      return {acc[LENGTH_BITS-5:0], d};
   endfunction

   // First character of the number proper (after whitespace or a sign).
   function automatic line_state_type digit_start(line_state_type s, logic [7:0] c);
      line_state_type r;
      r = s;
      if (c == CH_0) begin
         r.phase = PH_ZERO;
      end else if (is_hex(c)) begin
         r.accum = {{(LENGTH_BITS-4){1'b0}}, hex_digit(c)};
         r.phase = PH_DIGITS;
      end else begin
         r.phase = PH_REST;
      end
      return r;
   endfunction

   // One size-line character, CRLF already separated out.
   function automatic line_state_type line_char(line_state_type s, logic [7:0] c);
      line_state_type r;
      r = s;
      unique case (s.phase)
         PH_LEAD: begin
            if (is_space(c)) begin
               r = s;
            end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
               r.negative = (c == CH_MINUS);
               r.phase    = PH_SIGN;
            end else begin
               r = digit_start(s, c);
            end
         end
         PH_SIGN: r = digit_start(s, c);
         PH_ZERO: begin
            if ((c == CH_LOWER_X) || (c == CH_UPPER_X)) begin
               r.phase = PH_PREFIX;
            end else if (is_hex(c)) begin
               r.accum = accumulate(s.accum, hex_digit(c));
               r.phase = PH_DIGITS;
            end else begin
               r.phase = PH_REST;
            end
         end
         PH_PREFIX, PH_DIGITS: begin
            if (is_hex(c)) begin
               r.accum = accumulate(s.accum, hex_digit(c));
               r.phase = PH_DIGITS;
            end else begin
               r.phase = PH_REST;
            end
         end
         default: r = s;
      endcase
      return r;
   endfunction

   // One raw size-line byte: a pending CR either closes the line with LF or
   // is replayed as an ordinary character before this one.
   function automatic line_byte_type line_byte(line_state_type s, logic cr,
                                               logic [7:0] c);
      line_byte_type r;
      r.ls   = s;
      r.cr   = 1'b0;
      r.done = 1'b0;
      if (cr && (c == CH_LF)) begin
         r.done = 1'b1;
      end else begin
         if (cr) begin
            r.ls = line_char(r.ls, CH_CR);
         end
         r.cr = (c == CH_CR);
         if (!r.cr) begin
            r.ls = line_char(r.ls, c);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // CSRs and decoder state
   // ---------------------------------------------------------------------
   logic [1:0]             decode_mode_ff;
   logic [31:0]            content_length_ff;

   phase_type              phase_ff,         phase_in;
   logic [LENGTH_BITS-1:0] chunk_left_ff,    chunk_left_in;
   logic [LENGTH_BITS-1:0] size_accum_ff,    size_accum_in;
   logic                   size_negative_ff, size_negative_in;
   logic                   cr_seen_ff,       cr_seen_in;
   logic [31:0]            bytes_passed_ff,  bytes_passed_in;

   logic                   rsp_valid_ff;
   logic [7:0]             rsp_out_byte_ff,  rsp_out_byte_in;
   logic                   rsp_out_valid_ff, rsp_out_valid_in;
   logic                   rsp_out_end_ff;

   logic                   req_accept;
   logic                   pass;
   line_state_type         cur_line;
   line_byte_type          lb;
   logic [LENGTH_BITS-1:0] chunk_dec;

   // Take a new request whenever the result register is empty or draining.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign cur_line.phase    = phase_ff;
   assign cur_line.accum    = size_accum_ff;
   assign cur_line.negative = size_negative_ff;

   assign chunk_dec = (chunk_left_ff != '0) ? (chunk_left_ff - 1'b1) : chunk_left_ff;

   always_comb begin
      phase_in         = phase_ff;
      chunk_left_in    = chunk_left_ff;
      size_accum_in    = size_accum_ff;
      size_negative_in = size_negative_ff;
      cr_seen_in       = cr_seen_ff;
      bytes_passed_in  = bytes_passed_ff;
      pass             = 1'b0;
      lb.ls            = cur_line;
      lb.cr            = cr_seen_ff;
      lb.done          = 1'b0;

      unique case (decode_mode_ff)
         MODE_LENGTH: begin
            if (bytes_passed_ff < content_length_ff) begin
               pass            = 1'b1;
               bytes_passed_in = bytes_passed_ff + 32'd1;
            end
         end
         MODE_CHUNKED: begin
            unique case (phase_ff)
               PH_STOP: pass = 1'b0;
               PH_DATA: begin
                  pass          = 1'b1;
                  chunk_left_in = chunk_dec;
                  if (chunk_dec == '0) begin
                     phase_in = PH_AFTER;
                  end
               end
               PH_AFTER: begin
                  if (req_in_byte == CH_CR) begin
                     phase_in = PH_AFTCR;
                  end else begin
                     lb = line_byte('{phase: PH_LEAD, accum: size_accum_ff,
                                      negative: size_negative_ff},
                                    cr_seen_ff, req_in_byte);
                  end
               end
               PH_AFTCR: begin
                  // Drop the LF of the trailing CRLF; anything else opens a line.
                  if (req_in_byte == CH_LF) begin
                     phase_in = PH_LEAD;
                  end else begin
                     lb = line_byte('{phase: PH_LEAD, accum: size_accum_ff,
                                      negative: size_negative_ff},
                                    cr_seen_ff, req_in_byte);
                  end
               end
               default: lb = line_byte(cur_line, cr_seen_ff, req_in_byte);
            endcase

            if ((phase_ff != PH_STOP) && (phase_ff != PH_DATA) &&
                !((phase_ff == PH_AFTER) && (req_in_byte == CH_CR)) &&
                !((phase_ff == PH_AFTCR) && (req_in_byte == CH_LF))) begin
               if (lb.done) begin
                  // Close the size line: start a chunk or stop for good.
                  if (lb.ls.negative || (lb.ls.accum == '0)) begin
                     phase_in = PH_STOP;
                  end else begin
                     chunk_left_in = lb.ls.accum;
                     phase_in      = PH_DATA;
                  end
                  size_accum_in    = '0;
                  size_negative_in = 1'b0;
                  cr_seen_in       = 1'b0;
               end else begin
                  phase_in         = lb.ls.phase;
                  size_accum_in    = lb.ls.accum;
                  size_negative_in = lb.ls.negative;
                  cr_seen_in       = lb.cr;
               end
            end
         end
         default: pass = 1'b1;
      endcase

      // Return to the reset state after the final byte of a response.
      if (req_in_last) begin
         phase_in         = PH_LEAD;
         chunk_left_in    = '0;
         size_accum_in    = '0;
         size_negative_in = 1'b0;
         cr_seen_in       = 1'b0;
         bytes_passed_in  = '0;
      end

      rsp_out_valid_in = pass;
      rsp_out_byte_in  = pass ? req_in_byte : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff    <= MODE_RAW;
         content_length_ff <= '0;
         phase_ff          <= PH_LEAD;
         chunk_left_ff     <= '0;
         size_accum_ff     <= '0;
         size_negative_ff  <= 1'b0;
         cr_seen_ff        <= 1'b0;
         bytes_passed_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_DECODE_MODE) begin
               decode_mode_ff <= csr_wdata[1:0];
            end else if (csr_index == CSR_CONTENT_LENGTH) begin
               content_length_ff <= csr_wdata;
            end
         end
         if (req_accept) begin
            phase_ff         <= phase_in;
            chunk_left_ff    <= chunk_left_in;
            size_accum_ff    <= size_accum_in;
            size_negative_ff <= size_negative_in;
            cr_seen_ff       <= cr_seen_in;
            bytes_passed_ff  <= bytes_passed_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_out_byte_ff  <= rsp_out_byte_in;
         rsp_out_valid_ff <= rsp_out_valid_in;
         rsp_out_end_ff   <= req_in_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_end   = rsp_out_end_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_dropped_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_out_valid_ff |-> rsp_out_byte_ff == 8'd0)
      else $error("dropped byte carries nonzero data");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_in_last |=> phase_ff == PH_LEAD && bytes_passed_ff == 32'd0 &&
                                    size_accum_ff == '0 && !cr_seen_ff)
      else $error("state not cleared after final byte");

   a_stop_drops: assert property (@(posedge clock) disable iff (reset)
      req_accept && decode_mode_ff == MODE_CHUNKED && phase_ff == PH_STOP
      |=> !rsp_out_valid_ff)
      else $error("byte passed after chunked stream stopped");

   a_cr_only_in_line: assert property (@(posedge clock) disable iff (reset)
      cr_seen_ff |-> (phase_ff == PH_LEAD || phase_ff == PH_SIGN || phase_ff == PH_ZERO ||
                      phase_ff == PH_PREFIX || phase_ff == PH_DIGITS || phase_ff == PH_REST))
      else $error("pending CR outside a size line");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff && rsp_out_end_ff == $past(req_in_last))
      else $error("accepted request did not produce a result");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the HTTP body dechunker: raw, length and chunked decoding.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hbd_pkg::*;

   localparam int unsigned LEN_BITS    = 32;
   localparam int unsigned QUIET_LIMIT = 2000;   // cycles with no handshake before giving up
   localparam int unsigned HOLD_CYCLES = 300;    // long receiver stall
   localparam int unsigned PRINT_CAP   = 40;     // mismatch lines shown before going quiet

   // Mode value past the defined ones; decodes as raw passthrough.
   localparam logic [1:0] MODE_SPARE = 2'd3;
   // Register index past the end of the register list; writes must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 4'd9;

   localparam logic [LEN_BITS-1:0] SIZE_SAT = {LEN_BITS{1'b1}};

   // Parser phases: size line sub-states, then the body states.
   typedef enum logic [3:0] {
      LINE_LEAD, LINE_SIGN, LINE_ZERO, LINE_PREFIX, LINE_DIGITS, LINE_REST,
      BODY_DATA, BODY_TRAIL, BODY_TRAIL_CR, BODY_STOPPED
   } parse_phase_type;

   // One decoded result, in the order of the response ports.
   typedef struct packed {
      logic [7:0] data;
      logic       keep;
      logic       last;
   } body_result_type;

   typedef logic [7:0] byte_q_type[$];

   // ---------------------------------------------------------------------------------
   // DUT signals; every input starts at a known value.
   // ---------------------------------------------------------------------------------
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_in_byte = 8'h00;
   logic                      req_in_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic [7:0]                rsp_out_byte;
   logic                      rsp_out_valid;
   logic                      rsp_out_end;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = CSR_DECODE_MODE;
   logic [31:0]               csr_wdata   = 32'h0;

   http_body_dechunker_top #(.LENGTH_BITS(LEN_BITS)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_valid(rsp_out_valid),
      .rsp_out_end  (rsp_out_end),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------------------------
   int unsigned     send_idle_pct  = 0;
   int unsigned     recv_idle_pct  = 0;
   int unsigned     hold_left      = 0;
   int unsigned     requests_sent  = 0;
   int unsigned     responses_seen = 0;
   int unsigned     mismatches     = 0;
   int unsigned     quiet_cycles   = 0;
   body_result_type decoded_q[$];

   // Mirror of the registers (reset values) and of the parser state.
   logic [1:0]          cfg_mode     = MODE_RAW;
   logic [31:0]         cfg_length   = 32'h0;
   parse_phase_type     parse_phase  = LINE_LEAD;
   logic [LEN_BITS-1:0] chunk_left   = '0;
   logic [LEN_BITS-1:0] size_accum   = '0;
   logic                size_negative = 1'b0;
   logic                cr_pending   = 1'b0;
   logic [31:0]         passed_count = 32'h0;

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------
   function automatic int hex_digit(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A + HEX_ALPHA_BASE);
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A + HEX_ALPHA_BASE);
      return -1;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // Shift one hex digit into the size, saturating at all ones.
   function automatic void shift_in_digit(int d);
      logic [LEN_BITS+3:0] grown;
      if (size_accum > (SIZE_SAT >> 4)) begin
         size_accum = SIZE_SAT;
      end else begin
         grown = {size_accum, 4'h0} + d[3:0];
         size_accum = (grown > SIZE_SAT) ? SIZE_SAT : grown[LEN_BITS-1:0];
      end
   endfunction

   // Number parsing of a size line, one character at a time (CRLF already split off).
   function automatic void size_line_char(logic [7:0] c);
      int d;
      d = hex_digit(c);
      if (parse_phase == LINE_LEAD) begin
         if (is_blank(c)) return;
         if (c == CH_PLUS || c == CH_MINUS) begin
            size_negative = (c == CH_MINUS);
            parse_phase = LINE_SIGN;
            return;
         end
      end
      case (parse_phase)
         LINE_LEAD, LINE_SIGN: begin
            if (c == CH_0) parse_phase = LINE_ZERO;
            else if (d >= 0) begin
               size_accum = d[LEN_BITS-1:0];
               parse_phase = LINE_DIGITS;
            end else parse_phase = LINE_REST;
         end
         LINE_ZERO: begin
            if (c == CH_LOWER_X || c == CH_UPPER_X) parse_phase = LINE_PREFIX;
            else if (d >= 0) begin
               shift_in_digit(d);
               parse_phase = LINE_DIGITS;
            end else parse_phase = LINE_REST;
         end
         LINE_PREFIX, LINE_DIGITS: begin
            if (d >= 0) begin
               shift_in_digit(d);
               parse_phase = LINE_DIGITS;
            end else parse_phase = LINE_REST;
         end
         default: ;
      endcase
   endfunction

   function automatic void size_line_end();
      if (size_negative || size_accum == '0) begin
         parse_phase = BODY_STOPPED;
      end else begin
         chunk_left  = size_accum;
         parse_phase = BODY_DATA;
      end
      size_accum    = '0;
      size_negative = 1'b0;
      cr_pending    = 1'b0;
   endfunction

   // A CR only ends the line when LF follows; otherwise it is an ordinary character.
   function automatic void size_line_byte(logic [7:0] c);
      if (cr_pending) begin
         if (c == CH_LF) begin
            size_line_end();
            return;
         end
         size_line_char(CH_CR);
      end
      cr_pending = (c == CH_CR);
      if (!cr_pending) size_line_char(c);
   endfunction

   function automatic body_result_type decode_byte(logic [7:0] c, logic last);
      body_result_type r;
      logic            pass;
      pass = 1'b0;
      case (cfg_mode)
         MODE_LENGTH: begin
            if (passed_count < cfg_length) begin
               pass = 1'b1;
               passed_count++;
            end
         end
         MODE_CHUNKED: begin
            case (parse_phase)
               BODY_STOPPED: ;
               BODY_DATA: begin
                  pass = 1'b1;
                  if (chunk_left != '0) chunk_left--;
                  if (chunk_left == '0) parse_phase = BODY_TRAIL;
               end
               BODY_TRAIL: begin
                  if (c == CH_CR) parse_phase = BODY_TRAIL_CR;
                  else begin
                     parse_phase = LINE_LEAD;
                     size_line_byte(c);
                  end
               end
               BODY_TRAIL_CR: begin
                  parse_phase = LINE_LEAD;
                  if (c != CH_LF) size_line_byte(c);
               end
               default: size_line_byte(c);
            endcase
         end
         default: pass = 1'b1;
      endcase
      r.data = pass ? c : 8'h00;
      r.keep = pass;
      r.last = last;
      if (last) begin
         parse_phase   = LINE_LEAD;
         chunk_left    = '0;
         size_accum    = '0;
         size_negative = 1'b0;
         cr_pending    = 1'b0;
         passed_count  = 32'h0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------
   task automatic report_mismatch(string what);
      if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Sample both handshakes at the edge: predict on each accepted request, compare
   // each accepted response against the oldest prediction, and watch for a hang.
   always @(posedge clock) begin : scoreboard
      body_result_type want;
      body_result_type got;
      logic            req_fire;
      logic            rsp_fire;
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      if (req_fire) decoded_q = {decoded_q, decode_byte(req_in_byte, req_in_last)};
      if (rsp_fire) begin
         got = {rsp_out_byte, rsp_out_valid, rsp_out_end};
         if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("response %0d with nothing expected", responses_seen));
         end else begin
            want = decoded_q.pop_front();
            if (got.data !== want.data)
               report_mismatch($sformatf("response %0d: out_byte %h, expected %h",
                                         responses_seen, got.data, want.data));
            if (got.keep !== want.keep)
               report_mismatch($sformatf("response %0d: out_valid %b, expected %b",
                                         responses_seen, got.keep, want.keep));
            if (got.last !== want.last)
               report_mismatch($sformatf("response %0d: out_end %b, expected %b",
                                         responses_seen, got.last, want.last));
         end
         responses_seen++;
      end
      if (req_fire || rsp_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles, %0d results outstanding",
                  quiet_cycles, decoded_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: hold off for a counted stretch when asked, else stall at random.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   // Offer one request; gap first at random, then hold valid until it is taken.
   task automatic send_byte(logic [7:0] b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   // Write one register while the block is idle, then drop the write enable.
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] data);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_DECODE_MODE:    cfg_mode   = data[1:0];
         CSR_CONTENT_LENGTH: cfg_length = data;
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mode lives in the low bits; fill the rest with noise.
   task automatic set_mode(logic [1:0] mode);
      logic [31:0] word;
      word = $urandom();
      word[1:0] = mode;
      write_reg(CSR_DECODE_MODE, word);
   endtask

   // Text shorthand: '^' stands for CR and '~' for LF.
   function automatic void push_text(ref byte_q_type q, input string s);
      for (int i = 0; i < s.len(); i++) begin
         case (s[i])
            "^":     q = {q, CH_CR};
            "~":     q = {q, CH_LF};
            default: q = {q, 8'(s[i])};
         endcase
      end
   endfunction

   task automatic send_message(input byte_q_type q, input logic close);
      foreach (q[i]) send_byte(q[i], close && (i == q.size() - 1));
   endtask

   task automatic send_text(input string s, input logic close);
      byte_q_type q;
      push_text(q, s);
      send_message(q, close);
   endtask

   // Random well-formed size line: optional blank, sign, prefix, mixed case, extension.
   function automatic string size_line_text(int unsigned size);
      string s;
      string digits;
      digits = $sformatf("%0h", size);
      if ($urandom_range(1)) digits = digits.toupper();
      case ($urandom_range(5))
         0: s = " ";
         1: s = "\t";
         2: s = "^";
         default: s = "";
      endcase
      if ($urandom_range(3) == 0) s = {s, "+"};
      if ($urandom_range(3) == 0) s = {s, $urandom_range(1) ? "0x" : "0X"};
      else if ($urandom_range(3) == 0) s = {s, "0"};
      s = {s, digits};
      case ($urandom_range(5))
         0: s = {s, ";name=val"};
         1: s = {s, " ^ "};
         default: ;
      endcase
      return {s, "^~"};
   endfunction

   // Chunked body with random chunks, a random terminator and sometimes cut short.
   task automatic send_chunked_message();
      byte_q_type  msg;
      int unsigned size;
      int unsigned cut;
      if (cfg_mode != MODE_CHUNKED) set_mode(MODE_CHUNKED);
      repeat ($urandom_range(1, 3)) begin
         size = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
         push_text(msg, size_line_text(size));
         repeat (size) msg = {msg, 8'($urandom_range(255))};
         case ($urandom_range(7))
            0: ;
            1: msg = {msg, CH_CR};
            default: push_text(msg, "^~");
         endcase
      end
      case ($urandom_range(7))
         0: push_text(msg, "-2^~");
         1: push_text(msg, "^~");
         2: push_text(msg, "+^~");
         default: push_text(msg, size_line_text(0));
      endcase
      push_text(msg, "^~");
      if ($urandom_range(5) == 0) begin
         cut = $urandom_range(msg.size() - 1);
         msg = msg[0:cut];
      end
      send_message(msg, 1'b1);
   endtask

   // Chunked-mode garbage biased toward the characters the size parser cares about.
   task automatic send_noise_message();
      byte_q_type msg;
      logic [7:0] picks[10];
      picks = '{CH_CR, CH_LF, CH_0, CH_9, CH_LOWER_A, CH_UPPER_F, CH_LOWER_X,
                CH_PLUS, CH_MINUS, CH_SPACE};
      if (cfg_mode != MODE_CHUNKED) set_mode(MODE_CHUNKED);
      repeat ($urandom_range(1, 12))
         msg = {msg, $urandom_range(1) ? picks[$urandom_range(9)] : 8'($urandom_range(255))};
      send_message(msg, 1'b1);
   endtask

   task automatic send_length_message();
      byte_q_type  msg;
      logic [31:0] limit;
      case ($urandom_range(7))
         0: limit = 32'hFFFF_FFFF;
         1: limit = $urandom();
         default: limit = $urandom_range(12);
      endcase
      if (cfg_mode != MODE_LENGTH) set_mode(MODE_LENGTH);
      write_reg(CSR_CONTENT_LENGTH, limit);
      repeat ($urandom_range(1, 15)) msg = {msg, 8'($urandom_range(255))};
      send_message(msg, 1'b1);
   endtask

   task automatic send_raw_message();
      byte_q_type msg;
      set_mode($urandom_range(1) ? MODE_RAW : MODE_SPARE);
      repeat ($urandom_range(1, 10)) msg = {msg, 8'($urandom_range(255))};
      send_message(msg, 1'b1);
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Raw and spare mode pass every byte; a write past the register list changes nothing.
   task automatic test_raw_modes();
      byte_q_type msg;
      set_mode(MODE_RAW);
      msg = {8'h00, 8'hFF};
      send_message(msg, 1'b1);
      set_mode(MODE_SPARE);
      write_reg(CSR_SPARE_INDEX, 32'hFFFF_FFFF);
      send_text("~^", 1'b1);
   endtask

   // Length limit at zero, a small value, and the largest value.
   task automatic test_length_limit();
      set_mode(MODE_LENGTH);
      write_reg(CSR_CONTENT_LENGTH, 32'd0);
      send_text("a", 1'b1);
      write_reg(CSR_CONTENT_LENGTH, 32'd2);
      send_text("bcd", 1'b1);
      write_reg(CSR_CONTENT_LENGTH, 32'hFFFF_FFFF);
      send_text("ef", 1'b1);
   endtask

   task automatic test_chunked_size_lines();
      set_mode(MODE_CHUNKED);
      // lone CR as leading blank, sign, 0X prefix, lone CR ending the number,
      // CR after data with no LF, then a zero size that stops the body
      send_text("^+0X2^z^~ab^1^~c0^~q", 1'b1);
      // negative size, sign with no digits, empty line: all stop the body
      send_text("-1^~q", 1'b1);
      send_text("+^~q", 1'b1);
      send_text("^~q", 1'b1);
      // size too big for the counter saturates; data passes until the stream ends
      send_text("\tFFFFFFFFF^~xy", 1'b1);
   endtask

   // Register writes between requests leave the parser where it was.
   task automatic test_mode_switch_mid_chunk();
      set_mode(MODE_CHUNKED);
      send_text("3^~ab", 1'b0);
      set_mode(MODE_RAW);
      send_text("Z", 1'b0);
      set_mode(MODE_CHUNKED);
      send_text("c^~", 1'b1);
   endtask

   // Mixed traffic, mostly well-formed chunked bodies, until count more requests go in.
   task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                      int unsigned count);
      int unsigned stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         case ($urandom_range(9))
            0: send_length_message();
            1: send_raw_message();
            2: send_noise_message();
            default: send_chunked_message();
         endcase
      end
   endtask

   // Stall the receiver for a long stretch while requests keep coming, so the
   // block fills and drops req_ready; then pause until everything has drained.
   task automatic test_receiver_hold_off();
      byte_q_type msg;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_mode(MODE_RAW);
      hold_left = HOLD_CYCLES;
      repeat (40) msg = {msg, 8'($urandom_range(255))};
      send_message(msg, 1'b1);
      drain_results();
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------
   initial begin
      // hold reset, then release it once
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase one of idling: sender gaps are rare, receiver stalls most of the time
      send_idle_pct = 22;
      recv_idle_pct = 87;
      test_raw_modes();
      test_length_limit();
      test_chunked_size_lines();
      test_mode_switch_mid_chunk();
      test_random_traffic(22, 87, 130);

      // phase two: the other way round
      test_random_traffic(87, 22, 130);

      // phase three: no idling, plus the long stall
      test_receiver_hold_off();
      test_random_traffic(0, 0, 130);

      // wait out the last results and the pipeline
      drain_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
